/* sv/pcbb_pkg.sv */
// Package for the prefix-compressed block builder.
// Holds sizes, action codes and the sequencer request struct; no dependencies.
package pcbb_pkg;
  localparam int unsigned MaxKeyLen   = 32;
  localparam int unsigned MaxRestarts = 15;
  localparam int unsigned KeyPosW     = 6;
  localparam int unsigned KeyAddrW    = $clog2(MaxKeyLen);
  localparam int unsigned RstIdxW     = 4;

  typedef enum logic [1:0] {
    ACT_KEY    = 2'd0,
    ACT_VALUE  = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  localparam logic [0:0] REG_RESTART_INTERVAL = 1'b0;

  // Request from the front end to the byte emitter.
  typedef struct packed {
    logic                header;    // emit entry header plus key suffix
    logic                value;     // emit one value byte
    logic                finish;    // emit restart table and count
    logic [7:0]          data;
    logic [KeyPosW-1:0]  shared;
    logic [KeyPosW-1:0]  klen;
    logic [15:0]         vlen;
  } emit_req_t;
endpackage

/* sv/pcbb_emitter.sv */
// Byte emitter with a shared varint/word shifter; busy till its bytes are out.
// Depends on pcbb_pkg. Reads the key store and restart table of the top level.
module pcbb_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pcbb_pkg::emit_req_t   req_i,
  input  logic [7:0]            key_rdata_i,
  output logic [pcbb_pkg::KeyAddrW-1:0] key_raddr_o,
  input  logic [31:0]           rst_word_i,
  output logic [pcbb_pkg::RstIdxW-1:0]  rst_idx_o,
  input  logic [pcbb_pkg::RstIdxW-1:0]  rst_total_i,
  output logic                  busy_o,
  output logic                  byte_valid_o,
  output logic [7:0]            byte_o,
  output logic                  byte_last_o,
  input  logic                  byte_ready_i
);
  import pcbb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_VARINT, S_KEY, S_WORD, S_DONE
  } state_e;

  state_e             state_q;
  logic [1:0]         vsel_q;      // which header varint
  logic [31:0]        shreg_q;     // shared shift unit
  logic [1:0]         bcnt_q;      // word byte counter
  logic [KeyPosW-1:0] pos_q;
  logic [KeyPosW-1:0] klen_q;
  logic [15:0]        vlen_q;
  logic [KeyPosW-1:0] suff_q;
  logic [RstIdxW-1:0] ridx_q;
  logic               cnt_word_q;  // emitting the count word
  logic               fin_q;
  logic               key_pend_q;  // key or table read in flight
  logic [7:0]         byte_q;
  logic               last_q;
  logic               valid_q;

  logic free;
  assign free = !valid_q || byte_ready_i;

  logic [KeyPosW-1:0] key_end;
  assign key_end = (klen_q > KeyPosW'(MaxKeyLen)) ? KeyPosW'(MaxKeyLen) : klen_q;

  // First byte of a word comes straight from the table read (or the count).
  logic [31:0] word_cur;
  assign word_cur = (bcnt_q != 2'd0) ? shreg_q :
                    (cnt_word_q ? 32'(rst_total_i) : rst_word_i);

  assign key_raddr_o  = pos_q[KeyAddrW-1:0];
  assign rst_idx_o    = ridx_q;
  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;
  assign byte_last_o  = last_q;
  assign busy_o       = (state_q != S_IDLE) || valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= 1'b0;
      key_pend_q <= 1'b0;
      vsel_q     <= '0;
      bcnt_q     <= '0;
      ridx_q     <= '0;
      cnt_word_q <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      if (valid_q && byte_ready_i) valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            fin_q <= 1'b0;
            if (req_i.header) begin
              state_q <= S_VARINT;
              vsel_q  <= 2'd0;
              shreg_q <= 32'(req_i.shared);
              pos_q   <= req_i.shared;
              klen_q  <= req_i.klen;
              vlen_q  <= req_i.vlen;
              suff_q  <= req_i.klen - req_i.shared;
            end else if (req_i.value) begin
              byte_q  <= req_i.data;
              last_q  <= 1'b1;
              valid_q <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q    <= S_WORD;
              ridx_q     <= '0;
              bcnt_q     <= '0;
              cnt_word_q <= 1'b0;
              fin_q      <= 1'b1;
              key_pend_q <= 1'b1;   // wait for the table read
            end
          end
        end
        S_VARINT: begin
          if (free) begin
            valid_q <= 1'b1;
            if (shreg_q >= 32'h80) begin
              byte_q  <= {1'b1, shreg_q[6:0]};
              last_q  <= 1'b0;
              shreg_q <= shreg_q >> 7;
            end else begin
              byte_q <= shreg_q[7:0];
              unique case (vsel_q)
                2'd0: begin
                  vsel_q <= 2'd1; shreg_q <= 32'(suff_q); last_q <= 1'b0;
                end
                2'd1: begin
                  vsel_q <= 2'd2; shreg_q <= 32'(vlen_q); last_q <= 1'b0;
                end
                default: begin
                  last_q <= (pos_q >= key_end);
                  if (pos_q >= key_end) state_q <= S_DONE;
                  else begin
                    state_q    <= S_KEY;
                    key_pend_q <= 1'b1;
                  end
                end
              endcase
            end
          end
        end
        S_KEY: begin
          if (key_pend_q) key_pend_q <= 1'b0;
          else if (free) begin
            valid_q <= 1'b1;
            byte_q  <= key_rdata_i;
            last_q  <= (pos_q + 1'b1 >= key_end);
            if (pos_q + 1'b1 >= key_end) state_q <= S_DONE;
            else begin
              pos_q      <= pos_q + 1'b1;
              key_pend_q <= 1'b1;
            end
          end
        end
        S_WORD: begin
          if (key_pend_q) key_pend_q <= 1'b0;
          else if (free) begin
            valid_q <= 1'b1;
            byte_q  <= word_cur[7:0];
            shreg_q <= word_cur >> 8;
            bcnt_q  <= bcnt_q + 1'b1;
            last_q  <= cnt_word_q && (bcnt_q == 2'd3);
            if (bcnt_q == 2'd3) begin
              if (cnt_word_q) state_q <= S_DONE;
              else begin
                key_pend_q <= 1'b1;
                if (ridx_q + 1'b1 >= rst_total_i) cnt_word_q <= 1'b1;
                else ridx_q <= ridx_q + 1'b1;
              end
            end
          end
        end
        default: begin
          if (free) state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The count word is the last thing a finish puts out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q && fin_q) |-> cnt_word_q)
    else $error("finish ended before count word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !key_pend_q || fin_q)
    else $error("read pending while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !byte_ready_i) |=> (valid_q && $stable(byte_q)))
    else $error("output byte lost under stall");
endmodule

/* sv/prefix_compressed_block_builder.sv */
// Top level of the prefix-compressed block builder.
// Depends on pcbb_pkg and pcbb_emitter.
//
// Builds a sorted-table data block from a byte stream of keys and values.
// An accepted key byte holds the block not-ready in its compare state
// (F_CMP); a last key byte, a value byte or a finish keeps it not-ready
// while the byte emitter runs: header varints and stored suffix bytes for
// a last key byte, the byte for a value, and for finish a word (a table
// read plus four byte shifts) for every offset and the count. The
// emitter's one shared shift register serves varints and 32-bit words
// alike; output stalls lengthen its work. Keys are kept in a 32-entry byte
// store with registered reads for compare and emit. The overflow flag is
// sticky and reported on every output byte.
module prefix_compressed_block_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // data_byte[7:0], value_len[23:8]
  input  logic [1:0]  s_axis_tuser_i,  // action[1:0]
  input  logic        s_axis_tlast_i,  // key_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tuser_o,  // overflow
  output logic        m_axis_tlast_o,  // out_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pcbb_pkg::*;

  logic [15:0]        interval_q;
  logic [7:0]         key_store [MaxKeyLen];
  logic [31:0]        rst_offs_q [MaxRestarts];
  logic [KeyPosW-1:0] prev_len_q, key_pos_q, shared_q;
  logic               match_q;
  logic [15:0]        group_q;
  logic [RstIdxW-1:0] rst_total_q;
  logic [31:0]        written_q;
  logic               done_q, ovf_q;
  logic [7:0]         key_rd_q;   // registered compare read
  logic [7:0]         emit_rd_q;  // registered emitter read
  logic [31:0]        rst_rd_q;

  // Front end: accept, then a compare state (F_CMP) for key bytes.
  typedef enum logic [1:0] { F_IDLE, F_CMP, F_EMIT } fstate_e;
  fstate_e            fstate_q;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic [15:0]        in_vlen_q;

  logic               em_busy, em_start;
  emit_req_t          req;
  logic [KeyAddrW-1:0] em_addr;
  logic [RstIdxW-1:0] em_ridx;
  logic               bvalid, blast;
  logic [7:0]         bdata;

  action_e act;
  assign act = action_e'(s_axis_tuser_i);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESTART_INTERVAL) ? 32'(interval_q) : 32'd0;

  logic acc;
  assign s_axis_tready_o = (fstate_q == F_IDLE) && !em_busy;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // Entry start bookkeeping seen at the accepted item.
  logic [15:0] ivl;
  assign ivl = (interval_q == 16'd0) ? 16'd1 : interval_q;

  logic [KeyPosW-1:0] kp_eff;
  logic               restart_now;
  assign restart_now = (key_pos_q == '0) && (group_q >= ivl);

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_store[key_pos_q[KeyAddrW-1:0]];
    emit_rd_q <= key_store[em_addr];
    rst_rd_q  <= rst_offs_q[em_ridx];
    if (fstate_q == F_CMP && key_pos_q < KeyPosW'(MaxKeyLen))
      key_store[key_pos_q[KeyAddrW-1:0]] <= in_byte_q;
  end

  logic cmp_hit;
  assign cmp_hit = match_q && (key_pos_q < prev_len_q) && (key_rd_q == in_byte_q);
  assign kp_eff  = (key_pos_q < KeyPosW'(MaxKeyLen)) ? key_pos_q + 1'b1 : key_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= 16'd16;
      fstate_q    <= F_IDLE;
      prev_len_q  <= '0;
      key_pos_q   <= '0;
      shared_q    <= '0;
      match_q     <= 1'b1;
      group_q     <= '0;
      rst_total_q <= RstIdxW'(1);
      written_q   <= '0;
      done_q      <= 1'b0;
      ovf_q       <= 1'b0;
      rst_offs_q[0] <= '0;
      em_start    <= 1'b0;
    end else begin
      em_start <= 1'b0;
      if (psel && penable && pwrite && pready && paddr[2] == REG_RESTART_INTERVAL)
        interval_q <= pwdata[15:0];
      if (bvalid && m_axis_tready_i) written_q <= written_q + 32'd1;
      unique case (fstate_q)
        F_IDLE: begin
          if (acc && !done_q) begin
            in_byte_q <= s_axis_tdata_i[7:0];
            in_vlen_q <= s_axis_tdata_i[23:8];
            in_last_q <= s_axis_tlast_i;
            unique case (act)
              ACT_KEY: begin
                fstate_q <= F_CMP;
                if (key_pos_q == '0) begin
                  match_q  <= 1'b1;
                  shared_q <= '0;
                  if (restart_now) begin
                    if (rst_total_q < RstIdxW'(MaxRestarts)) begin
                      rst_offs_q[rst_total_q] <= written_q;
                      rst_total_q <= rst_total_q + 1'b1;
                      group_q     <= '0;
                      match_q     <= 1'b0;
                    end else ovf_q <= 1'b1;
                  end
                end
              end
              ACT_VALUE: begin
                if (key_pos_q == '0) begin
                  em_start <= 1'b1;
                  fstate_q <= F_EMIT;
                end
              end
              ACT_FINISH: begin
                key_pos_q <= '0;
                shared_q  <= '0;
                match_q   <= 1'b1;
                done_q    <= 1'b1;
                em_start  <= 1'b1;
                fstate_q  <= F_EMIT;
              end
              default: ;
            endcase
          end
        end
        F_CMP: begin
          if (key_pos_q < KeyPosW'(MaxKeyLen)) begin
            if (cmp_hit) shared_q <= shared_q + 1'b1;
            else match_q <= 1'b0;
          end else ovf_q <= 1'b1;
          if (in_last_q) begin
            em_start   <= 1'b1;
            fstate_q   <= F_EMIT;
            prev_len_q <= kp_eff;
            key_pos_q  <= '0;
            if (group_q != 16'hFFFF) group_q <= group_q + 1'b1;
          end else begin
            key_pos_q <= kp_eff;
            fstate_q  <= F_IDLE;
          end
        end
        default: begin
          if (in_last_q || !em_start) begin
            shared_q <= '0;
            match_q  <= 1'b1;
          end
          fstate_q <= F_IDLE;
        end
      endcase
    end
  end

  // Header values as they stand when the emitter starts.
  assign req.header = (fstate_q == F_EMIT) && in_last_q && !done_q;
  assign req.value  = !done_q;
  assign req.finish = done_q;
  assign req.data   = in_byte_q;
  assign req.shared = shared_q;
  assign req.klen   = prev_len_q;
  assign req.vlen   = in_vlen_q;

  // Value requests leave in_last_q from the value item; keep header separate.
  emit_req_t req_mux;
  logic      hdr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hdr_q <= 1'b0;
    else if (acc) hdr_q <= (act == ACT_KEY);
  end
  always_comb begin
    req_mux        = req;
    req_mux.header = hdr_q && !done_q;
    req_mux.value  = !hdr_q && !done_q;
  end

  pcbb_emitter u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (em_start),
    .req_i        (req_mux),
    .key_rdata_i  (emit_rd_q),
    .key_raddr_o  (em_addr),
    .rst_word_i   (rst_rd_q),
    .rst_idx_o    (em_ridx),
    .rst_total_i  (rst_total_q),
    .busy_o       (em_busy),
    .byte_valid_o (bvalid),
    .byte_o       (bdata),
    .byte_last_o  (blast),
    .byte_ready_i (m_axis_tready_i)
  );

  assign m_axis_tvalid_o = bvalid;
  assign m_axis_tdata_o  = bdata;
  assign m_axis_tlast_o  = blast;
  assign m_axis_tuser_o  = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_total_q >= RstIdxW'(1)) && (rst_total_q <= RstIdxW'(MaxRestarts)))
    else $error("restart count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ovf_q) |-> ovf_q)
    else $error("overflow flag not sticky");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !bvalid)
    else $error("accepting while output pending");
endmodule

/* verif/tb_prefix_compressed_block_builder.sv */
`timescale 1ns / 100ps
// Testbench for prefix_compressed_block_builder: directed table, then random entries.
// Depends on pcbb_pkg and the block's RTL; self-checking against an in-file block encoder.
module tb_prefix_compressed_block_builder;
  import pcbb_pkg::*;

  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic [7:0] out_byte;
    logic       out_last;
    logic       ovf;
  } block_byte_t;

  typedef struct {
    action_e    act;
    logic [7:0] data;
    logic       last;
    logic [15:0] vlen;
    bit         chk;       // first output byte typed in below
    logic [7:0] first_out;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = ACT_NONE;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  prefix_compressed_block_builder dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Encoder state, mirrors the block
  logic [7:0]  key_buf [MaxKeyLen];
  int unsigned prev_len, kpos, shared_cnt;
  bit          matching, block_closed, ovf_flag;
  int unsigned grp_count, n_restarts;
  logic [31:0] restart_off [MaxRestarts];
  logic [31:0] bytes_out;
  logic [15:0] interval;

  block_byte_t block_bytes_q[$];
  int unsigned errors = 0, items_in = 0, bytes_seen = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 0;

  task automatic put_varint(inout logic [7:0] q[$], input logic [31:0] v);
    while (v >= 32'h80) begin
      q.push_back(v[6:0] | 8'h80);
      v = v >> 7;
    end
    q.push_back(v[7:0]);
  endtask

  task automatic put_word(inout logic [7:0] q[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
  endtask

  // Encodes one accepted item; queues its bytes, returns the first one.
  task automatic encode_item(input action_e a, input logic [7:0] d, input logic l,
                             input logic [15:0] v, output logic [7:0] first);
    logic [7:0] q[$];
    int unsigned ivl;
    block_byte_t e;
    first = 'x;
    if (block_closed) return;
    case (a)
      ACT_KEY: begin
        if (kpos == 0) begin
          ivl = (interval == 0) ? 1 : interval;
          matching = 1;
          shared_cnt = 0;
          if (grp_count >= ivl) begin
            if (n_restarts < MaxRestarts) begin
              restart_off[n_restarts] = bytes_out;
              n_restarts++;
              grp_count = 0;
              matching = 0;
            end else ovf_flag = 1;
          end
        end
        if (kpos < MaxKeyLen) begin
          if (matching && kpos < prev_len && key_buf[kpos] == d) shared_cnt++;
          else matching = 0;
          key_buf[kpos] = d;
          kpos++;
        end else ovf_flag = 1;
        if (l) begin
          put_varint(q, shared_cnt);
          put_varint(q, kpos - shared_cnt);
          put_varint(q, 32'(v));
          for (int p = shared_cnt; p < kpos && p < MaxKeyLen; p++) q.push_back(key_buf[p]);
          bytes_out += q.size();
          prev_len = kpos;
          kpos = 0;
          shared_cnt = 0;
          matching = 1;
          if (grp_count < 16'hFFFF) grp_count++;
        end
      end
      ACT_VALUE: begin
        if (kpos != 0) return;
        q.push_back(d);
        bytes_out += 1;
      end
      ACT_FINISH: begin
        kpos = 0;
        shared_cnt = 0;
        matching = 1;
        for (int r = 0; r < n_restarts; r++) put_word(q, restart_off[r]);
        put_word(q, n_restarts);
        bytes_out += q.size();
        block_closed = 1;
      end
      default: return;  // no-op action
    endcase
    foreach (q[i]) begin
      e.out_byte = q[i];
      e.out_last = (i == q.size() - 1);
      e.ovf = ovf_flag;
      block_bytes_q.push_back(e);
    end
    if (q.size() != 0) first = q[0];
  endtask

  // Drives one item from a falling edge and holds it until the block takes it.
  task automatic send_item(input action_e a, input logic [7:0] d, input logic l,
                           input logic [15:0] v, output logic [7:0] first);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = a;
    s_axis_tdata_i = {v, d};
    s_axis_tlast_i = l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_in++;
    encode_item(a, d, l, v, first);
  endtask

  // Register write with readback, only while the block is idle.
  task automatic write_interval(input logic [15:0] val);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    repeat (40) @(negedge clk_i);  // let the block settle before the write
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {REG_RESTART_INTERVAL, 2'b00};
    pwdata = {16'h0, val};
    @(negedge clk_i) penable = 1'b1;
    @(negedge clk_i);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk_i) penable = 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== val) begin
      $display("%0t: restart_interval readback expected %0d, got %0d", $time, val, prdata[15:0]);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    interval = val;
  endtask

  // Output side: random back-pressure, none while calm
  always @(negedge clk_i)
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 10);

  // Result checker and stall watchdog
  always @(posedge clk_i) begin
    block_byte_t e;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) || psel)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("tb_prefix_compressed_block_builder: done, errors");
        $finish;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        bytes_seen <= bytes_seen + 1;
        if (block_bytes_q.size() == 0) begin
          $display("%0t: unexpected byte %h", $time, m_axis_tdata_o);
          errors++;
        end else begin
          e = block_bytes_q.pop_front();
          if (m_axis_tdata_o !== e.out_byte || m_axis_tlast_o !== e.out_last ||
              m_axis_tuser_o !== e.ovf) begin
            $display("%0t: expected byte %h last %b ovf %b, got byte %h last %b ovf %b",
                     $time, e.out_byte, e.out_last, e.ovf,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
            errors++;
          end
        end
      end
    end
  end

  // Directed rows: value bytes before any key, ignored items, varint edges, shared prefix
  stim_row_t directed [] = '{
    '{ACT_VALUE,  8'h00, 1'b0, 16'h0000, 1, 8'h00},
    '{ACT_VALUE,  8'hFF, 1'b1, 16'hFFFF, 1, 8'hFF},
    '{ACT_KEY,    8'h61, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_VALUE,  8'h55, 1'b0, 16'h0000, 0, 8'h00},  // ignored mid-key
    '{ACT_NONE,   8'hAA, 1'b1, 16'hFFFF, 0, 8'h00},  // ignored
    '{ACT_KEY,    8'h62, 1'b1, 16'h0000, 1, 8'h00},  // fresh block: shared 0
    '{ACT_VALUE,  8'h5A, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_KEY,    8'h61, 1'b1, 16'hFFFF, 1, 8'h01},  // one byte shared
    '{ACT_KEY,    8'h00, 1'b1, 16'd127,  0, 8'h00},
    '{ACT_KEY,    8'h00, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_KEY,    8'h00, 1'b1, 16'd128,  0, 8'h00},
    '{ACT_KEY,    8'hFF, 1'b1, 16'd16383, 0, 8'h00},
    '{ACT_KEY,    8'hFF, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_KEY,    8'hFF, 1'b1, 16'd16384, 0, 8'h00},
    '{ACT_VALUE,  8'h81, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_KEY,    8'hFF, 1'b0, 16'h0000, 0, 8'h00},
    '{ACT_KEY,    8'h7F, 1'b1, 16'h00FF, 0, 8'h00},
    '{ACT_NONE,   8'h00, 1'b0, 16'h0000, 0, 8'h00}
  };

  logic [7:0] prev_key[$];

  task automatic random_entries(input int unsigned n_entries);
    logic [7:0] key[$];
    logic [7:0] first;
    int unsigned klen, keep;
    for (int e = 0; e < n_entries; e++) begin
      // Mostly short keys, a few longer than the key store
      klen = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
      keep = (prev_key.size() == 0) ? 0 : $urandom_range(0, prev_key.size());
      key.delete();
      for (int i = 0; i < klen; i++)
        key.push_back((i < keep && $urandom_range(0, 7) != 0) ? prev_key[i] :
                      8'($urandom_range(0, 255)));
      for (int i = 0; i < klen; i++) begin
        if ($urandom_range(0, 29) == 0)  // noise inside a key
          send_item($urandom_range(0, 1) ? ACT_VALUE : ACT_NONE, 8'($urandom), 1'($urandom),
                    16'($urandom), first);
        send_item(ACT_KEY, key[i], i == klen - 1,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)), first);
      end
      prev_key = key;
      repeat ($urandom_range(0, 3))
        send_item(ACT_VALUE, 8'($urandom), 1'($urandom), 16'($urandom), first);
    end
  endtask

  initial begin
    logic [7:0] first;
    logic [15:0] ivls[5];
    prev_len = 0; kpos = 0; shared_cnt = 0; matching = 1; grp_count = 0;
    n_restarts = 1; restart_off[0] = '0; bytes_out = '0; block_closed = 0; ovf_flag = 0;
    interval = 16;
    ivls = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'($urandom_range(2, 9))};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i].act, directed[i].data, directed[i].last, directed[i].vlen, first);
      if (directed[i].chk && first !== directed[i].first_out) begin
        $display("%0t: row %0d first byte expected %h, got prediction %h",
                 $time, i, directed[i].first_out, first);
        errors++;
      end
    end

    // Phases at several restart intervals, extremes included
    foreach (ivls[p]) begin
      wait (block_bytes_q.size() == 0);
      write_interval(ivls[p]);
      calm = (p == 2);  // one stretch with no idling on either side
      random_entries(3);
    end
    calm = 0;

    // Finish with a partial key pending, then items that must be ignored
    send_item(ACT_KEY, 8'h11, 1'b0, 16'h0000, first);
    send_item(ACT_FINISH, 8'h00, 1'b0, 16'h0000, first);
    send_item(ACT_KEY, 8'h22, 1'b1, 16'h0001, first);
    send_item(ACT_VALUE, 8'h33, 1'b0, 16'h0000, first);
    send_item(ACT_FINISH, 8'h00, 1'b1, 16'h0000, first);
    @(negedge clk_i) s_axis_tvalid_i = 1'b0;

    wait (block_bytes_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items over 6 restart settings; checked %0d block bytes, overflow %0s.",
             items_in, bytes_seen, ovf_flag ? "reached" : "not reached");
    if (errors == 0 && block_bytes_q.size() == 0)
      $display("tb_prefix_compressed_block_builder: done, clean");
    else
      $display("tb_prefix_compressed_block_builder: done, errors");
    $finish;
  end
endmodule

/* sim.f */
sv/pcbb_pkg.sv
sv/pcbb_emitter.sv
sv/prefix_compressed_block_builder.sv
verif/tb_prefix_compressed_block_builder.sv
